>>> rtl/core/rlphp_pkg.sv
// rlphp_pkg: constants and types shared by the rlp stream header parser
// depends on nothing; imported by rlp_stream_header_parser_top
`default_nettype none

package rlphp_pkg;

    localparam int MAX_LENGTH_BYTES = 8;

    localparam logic [63:0] ACC_MASK = (MAX_LENGTH_BYTES >= 8) ? {64{1'b1}} :
        ((64'd1 << (8 * MAX_LENGTH_BYTES)) - 64'd1);

    typedef logic [1:0] phase_t;
    localparam phase_t PHASE_PREFIX  = 2'd0;
    localparam phase_t PHASE_LENGTH  = 2'd1;
    localparam phase_t PHASE_PAYLOAD = 2'd2;

    typedef logic [2:0] role_t;
    localparam role_t ROLE_FILLER   = 3'd0;
    localparam role_t ROLE_SINGLE   = 3'd1;
    localparam role_t ROLE_STR_HDR  = 3'd2;
    localparam role_t ROLE_LIST_HDR = 3'd3;
    localparam role_t ROLE_LEN_BYTE = 3'd4;
    localparam role_t ROLE_PAYLOAD  = 3'd5;

    localparam logic [7:0] BYTE_DEL       = 8'h7f;
    localparam logic [7:0] STR_SHORT_BASE = 8'h80;
    localparam logic [7:0] STR_SHORT_MAX  = 8'hb7;
    localparam logic [7:0] STR_LONG_MAX   = 8'hbf;
    localparam logic [7:0] LIST_SHORT_BASE = 8'hc0;
    localparam logic [7:0] LIST_SHORT_MAX = 8'hf7;

endpackage

`default_nettype wire

>>> rtl/core/rlp_stream_header_parser_top.sv
// an accepted byte is held in the input register, then the parse step writes its result to the result register
// throughput: one byte per cycle while the output is not stalled, set by the single registered parse step per byte;
// while a result is stalled at the output, the input register can still take one byte if it is empty
// reset clears the parse state and all valid flags; skip_del_reg comes up as 1
// rlp stream header parser top level, classifies each byte and reports completed headers
// depends on rlphp_pkg
`default_nettype none

module rlp_stream_header_parser_top
(
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  cfg_we,
    input  wire                  cfg_wdata,
    input  wire                  in_valid,
    output logic                 in_ready,
    input  wire  [7:0]           data_byte,
    output logic                 out_valid,
    input  wire                  out_ready,
    output logic [7:0]           byte_value,
    output rlphp_pkg::role_t     byte_role,
    output logic                 header_done,
    output logic                 item_is_list,
    output logic [63:0]          item_length,
    output logic [3:0]           header_size,
    output logic                 payload_last
);
    import rlphp_pkg::*;

    logic        skip_del_reg;
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        out_valid_reg;
    logic        advance;
    logic        step;

    phase_t      phase_reg, phase_next;
    logic [3:0]  len_left_reg, len_left_next;
    logic [63:0] acc_reg, acc_next;
    logic [63:0] payload_left_reg, payload_left_next;
    logic        pend_list_reg, pend_list_next;
    logic [3:0]  pend_hsize_reg, pend_hsize_next;

    role_t       role_c;
    logic        done_c;
    logic        is_list_c;
    logic [63:0] ilen_c;
    logic [3:0]  hsize_c;
    logic        last_c;
    logic [63:0] acc_shift;
    logic [3:0]  len_dec;
    logic [63:0] pay_dec;
    logic [3:0]  long_cnt;

    assign advance   = !out_valid_reg || out_ready;
    assign in_ready  = !in_valid_reg || advance;
    assign step      = in_valid_reg && advance;
    assign out_valid = out_valid_reg;

    assign acc_shift = ((acc_reg << 8) | {56'd0, in_byte_reg}) & ACC_MASK;
    assign len_dec   = (len_left_reg != 4'd0) ? len_left_reg - 4'd1 : 4'd0;
    assign pay_dec   = (payload_left_reg != 64'd0) ? payload_left_reg - 64'd1 : 64'd0;

    always_comb
    begin
        phase_next        = phase_reg;
        len_left_next     = len_left_reg;
        acc_next          = acc_reg;
        payload_left_next = payload_left_reg;
        pend_list_next    = pend_list_reg;
        pend_hsize_next   = pend_hsize_reg;
        role_c            = ROLE_FILLER;
        done_c            = 1'b0;
        is_list_c         = 1'b0;
        ilen_c            = 64'd0;
        hsize_c           = 4'd0;
        last_c            = 1'b0;
        long_cnt          = 4'd0;
        case (phase_reg)
            PHASE_LENGTH:
            begin
                role_c        = ROLE_LEN_BYTE;
                acc_next      = acc_shift;
                len_left_next = len_dec;
                if (len_dec == 4'd0)
                begin
                    done_c    = 1'b1;
                    is_list_c = pend_list_reg;
                    ilen_c    = acc_shift;
                    hsize_c   = pend_hsize_reg;
                    if (!pend_list_reg && acc_shift != 64'd0)
                    begin
                        payload_left_next = acc_shift;
                        phase_next        = PHASE_PAYLOAD;
                    end
                    else
                    begin
                        phase_next = PHASE_PREFIX;
                    end
                end
            end
            PHASE_PAYLOAD:
            begin
                role_c            = ROLE_PAYLOAD;
                payload_left_next = pay_dec;
                if (pay_dec == 64'd0)
                begin
                    last_c     = 1'b1;
                    phase_next = PHASE_PREFIX;
                end
            end
            default:
            begin
                phase_next = PHASE_PREFIX;
                if (in_byte_reg == BYTE_DEL && skip_del_reg)
                begin
                    role_c = ROLE_FILLER;
                end
                else if (in_byte_reg <= BYTE_DEL)
                begin
                    role_c = ROLE_SINGLE;
                    done_c = 1'b1;
                    ilen_c = 64'd1;
                end
                else if (in_byte_reg <= STR_SHORT_MAX)
                begin
                    role_c  = ROLE_STR_HDR;
                    done_c  = 1'b1;
                    ilen_c  = {56'd0, 8'(in_byte_reg - STR_SHORT_BASE)};
                    hsize_c = 4'd1;
                    if (ilen_c != 64'd0)
                    begin
                        payload_left_next = ilen_c;
                        phase_next        = PHASE_PAYLOAD;
                    end
                end
                else if (in_byte_reg <= STR_LONG_MAX)
                begin
                    role_c          = ROLE_STR_HDR;
                    long_cnt        = 4'(in_byte_reg - STR_SHORT_MAX);
                    len_left_next   = long_cnt;
                    acc_next        = 64'd0;
                    pend_list_next  = 1'b0;
                    pend_hsize_next = long_cnt + 4'd1;
                    phase_next      = PHASE_LENGTH;
                end
                else if (in_byte_reg <= LIST_SHORT_MAX)
                begin
                    role_c    = ROLE_LIST_HDR;
                    done_c    = 1'b1;
                    is_list_c = 1'b1;
                    ilen_c    = {56'd0, 8'(in_byte_reg - LIST_SHORT_BASE)};
                    hsize_c   = 4'd1;
                end
                else
                begin
                    // long list header: length bytes follow, no payload phase
                    role_c          = ROLE_LIST_HDR;
                    long_cnt        = 4'(in_byte_reg - LIST_SHORT_MAX);
                    len_left_next   = long_cnt;
                    acc_next        = 64'd0;
                    pend_list_next  = 1'b1;
                    pend_hsize_next = long_cnt + 4'd1;
                    phase_next      = PHASE_LENGTH;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skip_del_reg     <= 1'b1;
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            phase_reg        <= PHASE_PREFIX;
            len_left_reg     <= 4'd0;
            acc_reg          <= 64'd0;
            payload_left_reg <= 64'd0;
            pend_list_reg    <= 1'b0;
            pend_hsize_reg   <= 4'd0;
        end
        else
        begin
            if (cfg_we)
            begin
                skip_del_reg <= cfg_wdata;
            end
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (step)
            begin
                phase_reg        <= phase_next;
                len_left_reg     <= len_left_next;
                acc_reg          <= acc_next;
                payload_left_reg <= payload_left_next;
                pend_list_reg    <= pend_list_next;
                pend_hsize_reg   <= pend_hsize_next;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_byte_reg <= data_byte;
        end
        if (step)
        begin
            byte_value   <= in_byte_reg;
            byte_role    <= role_c;
            header_done  <= done_c;
            item_is_list <= is_list_c;
            item_length  <= ilen_c;
            header_size  <= hsize_c;
            payload_last <= last_c;
        end
    end

    a_payload_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PHASE_PAYLOAD |-> payload_left_reg != 64'd0)
        else $error("payload phase with zero bytes left");

    a_length_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PHASE_LENGTH |-> len_left_reg != 4'd0)
        else $error("length phase with zero length bytes left");

    a_done_role: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && header_done |-> byte_role == ROLE_SINGLE
            || byte_role == ROLE_STR_HDR || byte_role == ROLE_LIST_HDR
            || byte_role == ROLE_LEN_BYTE)
        else $error("header completed on a byte that is not part of a header");

    a_last_role: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && payload_last |-> byte_role == ROLE_PAYLOAD && !header_done)
        else $error("payload end flagged on a non-payload byte");

    a_step_leaves_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        step && phase_reg == PHASE_PAYLOAD && payload_left_reg == 64'd1
            |=> phase_reg == PHASE_PREFIX)
        else $error("parser did not return to prefix after the last payload byte");

endmodule

`default_nettype wire
